// ----- design/bte_pkg.sv -----
package bte_pkg;

  // Default store geometry
  localparam int MAX_ROWS_DEF = 128;
  localparam int MAX_COLS_DEF = 128;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int ROW_W     = 7;
  localparam int COL_W     = 7;
  localparam int PIX_W     = 8;
  localparam int CNT_W     = 15;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_ROWS_RST = 8'd128;
  localparam logic [CFG_W-1:0] IMAGE_COLS_RST = 8'd128;

  // Pass counter saturation value
  localparam logic [CNT_W-1:0] PASS_MAX = '1;

  // Controller to datapath
  typedef struct packed {
    logic pix_write;   // store one pixel from the request
    logic pix_read;    // issue a store read for the request
    logic rd_load;     // load a read result into the output register
    logic run_clear;   // zero the pass counter
    logic pass_start;  // rewind the sweep counters, clear the change flag
    logic pass_step;   // issue one column of the sweep
    logic pass_end;    // count the finished pass
    logic run_load;    // load a run result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic small_img;   // fewer than three rows or columns in use
    logic last_issue;  // sweep is at the last column of the last interior row
    logic changed;     // the pass just finished cleared a pixel
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

// ----- design/bte_ctrl.sv -----
module bte_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [bte_pkg::CMD_W-1:0]   in_cmd,
  output logic                        in_stall,
  input  bte_pkg::status_t            status,
  output bte_pkg::ctrl_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_PEND  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            bte_pkg::CMD_WRITE: begin
              cmd.pix_write = 1'b1;
            end
            bte_pkg::CMD_READ: begin
              cmd.pix_read = 1'b1;
              state_nxt    = S_READ;
            end
            bte_pkg::CMD_RUN: begin
              cmd.run_clear  = 1'b1;
              cmd.pass_start = 1'b1;
              state_nxt      = status.small_img ? S_PEND : S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (status.out_free) begin
          cmd.rd_load = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.pass_step = 1'b1;
        if (status.last_issue) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last column is judged in this cycle
        state_nxt = S_PEND;
      end
      S_PEND: begin
        cmd.pass_end = 1'b1;
        if (status.changed) begin
          cmd.pass_start = 1'b1;
          state_nxt      = S_SWEEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.run_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/bte_datapath.sv -----
module bte_datapath #(
  parameter int MAX_ROWS = bte_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bte_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bte_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [bte_pkg::ROW_W-1:0]       in_row,
  input  logic [bte_pkg::COL_W-1:0]       in_col,
  input  logic [bte_pkg::PIX_W-1:0]       in_pixel_in,
  input  logic                            out_stall,
  input  bte_pkg::ctrl_cmd_t              cmd,
  output bte_pkg::status_t                status,
  output logic                            out_valid,
  output logic [bte_pkg::PIX_W-1:0]       out_pixel_out,
  output logic [bte_pkg::CNT_W-1:0]       out_pass_count,
  output logic                            out_is_run_result
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = bte_pkg::PIX_W;

  // Configuration
  logic [bte_pkg::CFG_W-1:0] image_rows_r;
  logic [bte_pkg::CFG_W-1:0] image_cols_r;
  logic [RCW-1:0]            rows_eff;
  logic [CCW-1:0]            cols_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r <= bte_pkg::IMAGE_ROWS_RST;
      image_cols_r <= bte_pkg::IMAGE_COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bte_pkg::CFG_IMAGE_ROWS: image_rows_r <= cfg_wdata;
        bte_pkg::CFG_IMAGE_COLS: image_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_rows_r) > MAX_ROWS) rows_eff = RCW'(MAX_ROWS);
    else                              rows_eff = RCW'(image_rows_r);
    if (32'(image_cols_r) > MAX_COLS) cols_eff = CCW'(MAX_COLS);
    else                              cols_eff = CCW'(image_cols_r);
  end

  // Sweep counters
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [AW-1:0] base_r;
  logic          last_col;
  logic          last_row;

  assign last_col = (CCW'(col_r) == cols_eff - CCW'(1));
  assign last_row = (RCW'(row_r) == rows_eff - RCW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
    end else if (cmd.pass_start) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
    end else if (cmd.pass_step) begin
      if (last_col) begin
        col_r  <= '0;
        row_r  <= row_r + RW'(1);
        base_r <= base_r + AW'(MAX_COLS);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Addresses
  logic          in_inside;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] below_addr;

  assign in_inside  = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
  assign in_addr    = AW'(32'(in_row) * MAX_COLS + 32'(in_col));
  assign cur_addr   = base_r + AW'(col_r);
  assign below_addr = base_r + AW'(MAX_COLS) + AW'(col_r);

  // Pixel store: one write port, two registered read ports
  logic [PW-1:0] store_mem [DEPTH];
  logic          store_we;
  logic [AW-1:0] store_waddr;
  logic [PW-1:0] store_wdata;
  logic          re_a;
  logic [AW-1:0] raddr_a;
  logic [PW-1:0] q_a_r;
  logic [PW-1:0] q_b_r;

  assign re_a    = cmd.pix_read | cmd.pass_step;
  assign raddr_a = cmd.pix_read ? in_addr : cur_addr;

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= store_wdata;
    if (re_a) q_a_r <= store_mem[raddr_a];
    if (cmd.pass_step) q_b_r <= store_mem[below_addr];
  end

  // Line buffer with the pass-start copy of the row above
  logic [PW-1:0] prev_mem [MAX_COLS];
  logic [PW-1:0] prev_q_r;

  // Column stage following the read
  logic          valid_b_r;
  logic [CW-1:0] col_b_r;
  logic [AW-1:0] base_b_r;
  logic          first_row_b_r;

  always_ff @(posedge clk) begin
    if (cmd.pass_step) prev_q_r <= prev_mem[col_r];
    if (valid_b_r) prev_mem[col_b_r] <= q_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else begin
      valid_b_r <= cmd.pass_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_step) begin
      col_b_r       <= col_r;
      base_b_r      <= base_r;
      first_row_b_r <= (row_r == '0);
    end
  end

  // Window centred one column behind the newest read
  logic [PW-1:0] left_r;
  logic [PW-1:0] mid_r;
  logic [PW-1:0] pv_r;
  logic [PW-1:0] bl_r;

  always_ff @(posedge clk) begin
    if (valid_b_r) begin
      left_r <= mid_r;
      mid_r  <= q_a_r;
      pv_r   <= prev_q_r;
      bl_r   <= q_b_r;
    end
  end

  logic          ero_hit;
  logic [AW-1:0] ero_addr;

  assign ero_hit = valid_b_r && !first_row_b_r && (col_b_r >= CW'(2)) && (mid_r != '0) &&
                   (((left_r == '0) && (q_a_r == '0)) || ((pv_r == '0) && (bl_r == '0)));
  assign ero_addr = base_b_r + AW'(col_b_r) - AW'(1);

  assign store_we    = ero_hit || (cmd.pix_write && in_inside);
  assign store_waddr = cmd.pix_write ? in_addr : ero_addr;
  assign store_wdata = cmd.pix_write ? in_pixel_in : '0;

  // Pass bookkeeping
  logic                      changed_r;
  logic [bte_pkg::CNT_W-1:0] passes_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r <= 1'b0;
    end else if (cmd.pass_start) begin
      changed_r <= 1'b0;
    end else if (ero_hit) begin
      changed_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passes_done_r <= '0;
    end else if (cmd.run_clear) begin
      passes_done_r <= '0;
    end else if (cmd.pass_end && (passes_done_r != bte_pkg::PASS_MAX)) begin
      passes_done_r <= passes_done_r + bte_pkg::CNT_W'(1);
    end
  end

  // Output register
  logic                      rd_inside_r;
  logic                      out_valid_r;
  logic [PW-1:0]             out_pixel_r;
  logic [bte_pkg::CNT_W-1:0] out_count_r;
  logic                      out_run_r;
  logic                      out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.pix_read) rd_inside_r <= in_inside;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rd_load || cmd.run_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      out_pixel_r <= rd_inside_r ? q_a_r : '0;
      out_count_r <= passes_done_r;
      out_run_r   <= 1'b0;
    end else if (cmd.run_load) begin
      out_pixel_r <= '0;
      out_count_r <= passes_done_r;
      out_run_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = out_pixel_r;
  assign out_pass_count    = out_count_r;
  assign out_is_run_result = out_run_r;

  assign status.small_img  = (rows_eff < RCW'(3)) || (cols_eff < CCW'(3));
  assign status.last_issue = last_col && last_row;
  assign status.changed    = changed_r;
  assign status.out_free   = out_free;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_load || cmd.run_load) |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending result");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.pix_write, cmd.pix_read, cmd.pass_step, cmd.rd_load, cmd.run_load}))
    else $error("conflicting store or output commands");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.run_clear)) |-> (passes_done_r >= $past(passes_done_r)))
    else $error("pass count fell outside a run start");
`endif

endmodule

// ----- design/binary_tine_erosion.sv -----
// Binary tine erosion engine. Load an image with write requests (one pixel per cycle,
// row-major store of MAX_ROWS x MAX_COLS bytes), then issue a run request: the engine
// sweeps the image pass after pass, clearing every interior foreground pixel whose left
// and right neighbours are both zero or whose upper and lower neighbours are both zero,
// judged against the image as it stood at the start of the pass, until a pass clears
// nothing. Border pixels and surviving pixels keep their bytes. The run answers with the
// pass count (including the final quiet pass, saturating at 32767); read requests answer
// with the stored byte and the latest pass count. A read passes through a registered store
// read before it is loaded into the output register. Each pass sweeps every column of the
// first R - 1 of the R used rows; an image under three rows or columns gets a single pass
// and no sweep. The sweep is bound by the pixel store ports: one column per
// cycle, reading the current and the lower row, writing back cleared pixels one column
// behind, with the pass-start copy of the upper row held in a line buffer. The store is
// not cleared at reset; pixels must be written before they are read or swept. Image size
// registers may be written only while no request is in flight.
module binary_tine_erosion #(
  parameter int MAX_ROWS = bte_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bte_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [bte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bte_pkg::CFG_W-1:0]       cfg_wdata,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bte_pkg::CMD_W-1:0]       in_cmd,
  input  logic [bte_pkg::ROW_W-1:0]       in_row,
  input  logic [bte_pkg::COL_W-1:0]       in_col,
  input  logic [bte_pkg::PIX_W-1:0]       in_pixel_in,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bte_pkg::PIX_W-1:0]       out_pixel_out,
  output logic [bte_pkg::CNT_W-1:0]       out_pass_count,
  output logic                            out_is_run_result
);

  bte_pkg::ctrl_cmd_t cmd;
  bte_pkg::status_t   status;

  // Sequence requests and passes
  bte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the store, sweep window and output register
  bte_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_pixel_in       (in_pixel_in),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_pixel_out     (out_pixel_out),
    .out_pass_count    (out_pass_count),
    .out_is_run_result (out_is_run_result)
  );

endmodule
